// File: design/dmxtx_pkg.sv
// ----------------------------------------------------------------------------
// dmxtx_pkg
// shared types and constants of the dmx512 frame transmitter
// ----------------------------------------------------------------------------
package dmxtx_pkg;

    // field widths
    localparam int FRAME_PERIOD_W = 16;
    localparam int SLOT_COUNT_W   = 10;
    localparam int TICKS_W        = 8;
    localparam int SLOT_IDX_W     = 9;
    localparam int SLOT_DATA_W    = 8;
    localparam int BIT_POS_W      = 4;

    // port widths
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;   // slot_index + slot_data, padded to bytes
    localparam int M_TDATA_W  = 8;    // line_level + sync_level, padded to a byte

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_COUNT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BREAK_TICKS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAB_TICKS    = 2'd3;

    // register reset values
    localparam logic [FRAME_PERIOD_W-1:0] FRAME_PERIOD_RST = 16'd5682;
    localparam logic [SLOT_COUNT_W-1:0]   SLOT_COUNT_RST   = 10'd0;
    localparam logic [TICKS_W-1:0]        BREAK_TICKS_RST  = 8'd25;
    localparam logic [TICKS_W-1:0]        MAB_TICKS_RST    = 8'd3;

    // item kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // frame timing constants
    localparam logic [TICKS_W-1:0]   SC_LOW_TICKS  = 8'd9;
    localparam logic [TICKS_W-1:0]   SC_HIGH_TICKS = 8'd2;
    localparam logic [BIT_POS_W-1:0] LAST_BIT_POS  = 4'd10;
    localparam logic [BIT_POS_W-1:0] LAST_DATA_POS = 4'd8;

    typedef struct packed {
        logic [FRAME_PERIOD_W-1:0] frame_period;
        logic [SLOT_COUNT_W-1:0]   slot_count;
        logic [TICKS_W-1:0]        break_ticks;
        logic [TICKS_W-1:0]        mab_ticks;
    } t_cfg;

endpackage

// File: design/dmxtx_store.sv
// ----------------------------------------------------------------------------
// dmxtx_store
// slot byte memory with a clearing sweep after reset and write-to-read bypass
// ----------------------------------------------------------------------------
module dmxtx_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [dmxtx_pkg::SLOT_DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [dmxtx_pkg::SLOT_DATA_W-1:0] o_rdata,
    output logic                          o_busy
);
    import dmxtx_pkg::*;

    logic [SLOT_DATA_W-1:0] r_mem [DEPTH];
    logic [SLOT_DATA_W-1:0] r_rd;
    logic [SLOT_DATA_W-1:0] r_byp_data;
    logic                   r_byp;
    logic                   r_busy;
    logic [AW-1:0]          r_clr_addr;

    logic                   w_we;
    logic [AW-1:0]          w_wa;
    logic [SLOT_DATA_W-1:0] w_wd;

    // the sweep owns the write port until every entry is zero
    assign w_we = r_busy | i_we;
    assign w_wa = r_busy ? r_clr_addr : i_waddr;
    assign w_wd = r_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd       <= r_mem[i_raddr];
        r_byp      <= w_we && (w_wa == i_raddr);
        r_byp_data <= w_wd;
    end

    assign o_rdata = r_byp ? r_byp_data : r_rd;
    assign o_busy  = r_busy;

endmodule

// File: design/dmxtx_seq.sv
// ----------------------------------------------------------------------------
// dmxtx_seq
// frame sequencer: period counter, phase timing and slot bit walk
// ----------------------------------------------------------------------------
module dmxtx_seq #(
    parameter int MAX_SLOTS = 512,
    parameter int AW        = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  dmxtx_pkg::t_cfg               i_cfg,
    input  logic [dmxtx_pkg::SLOT_DATA_W-1:0] i_rd_byte,
    output logic [AW-1:0]                 o_raddr,
    output logic                          o_line,
    output logic                          o_sync
);
    import dmxtx_pkg::*;

    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BREAK,
        PH_MAB,
        PH_SC_LOW,
        PH_SC_HIGH,
        PH_SLOT
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [FRAME_PERIOD_W-1:0] r_pc, n_pc;
    logic [TICKS_W-1:0]        r_ptc, n_ptc;
    logic [AW-1:0]             r_slot, n_slot;
    logic [BIT_POS_W-1:0]      r_bit, n_bit;
    logic                      r_line, n_line;
    logic                      r_sync, n_sync;

    logic [SLOT_COUNT_W-1:0]   w_act_full;
    logic [SW-1:0]             w_active;
    logic                      w_start;
    t_phase                    w_phase;
    logic [TICKS_W-1:0]        w_ptc;
    logic [FRAME_PERIOD_W-1:0] w_pc;
    logic [TICKS_W-1:0]        w_len;
    logic                      w_done;
    logic [TICKS_W-1:0]        w_ptc_adv;
    logic [SW-1:0]             w_slot_inc;
    logic                      w_slot_end;
    logic [2:0]                w_bitsel;

    // slot count clipped to the store depth
    assign w_act_full = (i_cfg.slot_count > SLOT_COUNT_W'(MAX_SLOTS)) ?
                        SLOT_COUNT_W'(MAX_SLOTS) : i_cfg.slot_count;
    assign w_active   = w_act_full[SW-1:0];

    // break begins on this tick once the period has run out
    assign w_start = (r_phase == PH_IDLE) && (r_pc >= i_cfg.frame_period);
    assign w_phase = w_start ? PH_BREAK : r_phase;
    assign w_ptc   = w_start ? '0 : r_ptc;
    assign w_pc    = w_start ? '0 : r_pc;

    always_comb begin
        case (w_phase)
            PH_BREAK:   w_len = i_cfg.break_ticks;
            PH_MAB:     w_len = i_cfg.mab_ticks;
            PH_SC_LOW:  w_len = SC_LOW_TICKS;
            PH_SC_HIGH: w_len = SC_HIGH_TICKS;
            default:    w_len = TICKS_W'(1);
        endcase
    end

    // zero length counts as one tick
    assign w_done     = ({1'b0, w_ptc} + (TICKS_W+1)'(1)) >= {1'b0, w_len};
    assign w_ptc_adv  = w_done ? '0 : (w_ptc + TICKS_W'(1));
    assign w_slot_inc = {1'b0, r_slot} + SW'(1);
    assign w_slot_end = w_slot_inc >= w_active;
    assign w_bitsel   = 3'(r_bit - BIT_POS_W'(1));

    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_ptc   = r_ptc;
        n_slot  = r_slot;
        n_bit   = r_bit;
        n_line  = r_line;
        n_sync  = r_sync;
        if (i_tick) begin
            n_phase = w_phase;
            n_ptc   = w_ptc;
            n_line  = 1'b1;
            n_sync  = 1'b0;
            unique case (w_phase)
                PH_IDLE: begin
                end
                PH_BREAK: begin
                    n_line = 1'b0;
                    n_ptc  = w_ptc_adv;
                    if (w_done) begin
                        n_phase = PH_MAB;
                    end
                end
                PH_MAB: begin
                    n_sync = 1'b1;
                    n_ptc  = w_ptc_adv;
                    if (w_done) begin
                        n_phase = PH_SC_LOW;
                    end
                end
                PH_SC_LOW: begin
                    n_line = 1'b0;
                    n_sync = 1'b1;
                    n_ptc  = w_ptc_adv;
                    if (w_done) begin
                        n_phase = PH_SC_HIGH;
                    end
                end
                PH_SC_HIGH: begin
                    n_ptc = w_ptc_adv;
                    if (w_done) begin
                        n_slot  = '0;
                        n_bit   = '0;
                        n_phase = (w_active == '0) ? PH_IDLE : PH_SLOT;
                    end
                end
                PH_SLOT: begin
                    // start bit, data lsb first, then stop bits
                    if (r_bit == '0) begin
                        n_line = 1'b0;
                    end else if (r_bit <= LAST_DATA_POS) begin
                        n_line = i_rd_byte[w_bitsel];
                    end else begin
                        n_line = 1'b1;
                    end
                    if (r_bit >= LAST_BIT_POS) begin
                        n_bit = '0;
                        if (w_slot_end) begin
                            n_slot  = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_slot = w_slot_inc[AW-1:0];
                        end
                    end else begin
                        n_bit = r_bit + BIT_POS_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // ticks since the last break start, saturating
            n_pc = (w_pc != '1) ? (w_pc + FRAME_PERIOD_W'(1)) : w_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pc    <= '0;
            r_ptc   <= '0;
            r_slot  <= '0;
            r_bit   <= '0;
            r_line  <= 1'b1;
            r_sync  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_ptc   <= n_ptc;
            r_slot  <= n_slot;
            r_bit   <= n_bit;
            r_line  <= n_line;
            r_sync  <= n_sync;
        end
    end

    // next slot address, so the store read is ready for the following tick
    assign o_raddr = n_slot;
    assign o_line  = n_line;
    assign o_sync  = n_sync;

`ifndef SYNTHESIS
    a_sync_rises_on_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sync) |-> r_line)
        else $error("sync rose while the line was low");

    a_sync_low_line_in_sc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sync && !r_line) |-> (r_phase == PH_SC_LOW || r_phase == PH_SC_HIGH))
        else $error("line low with sync high outside the start code");

    a_break_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BREAK) |-> (!r_line && !r_sync))
        else $error("break phase without a low line");
`endif

endmodule

// File: design/dmx512_frame_transmitter.sv
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter
// dmx512 line generator driven by bit-time ticks, with a slot byte store
// ----------------------------------------------------------------------------
//
// channel   direction  transfer when              contents
// s_axis    in         i_s_tvalid & o_s_tready    tick or slot byte write
// m_axis    out        o_m_tvalid & i_m_tready    line and sync level
// cfg       in         i_cfg_valid & o_cfg_ready  register index and value
//
// one item per cycle sustained while the result side does not stall and the
// store sweep is over, limited by the frame sequencer's combinational next-state
// logic and the store's registered read port; an item passes the input register,
// then the result register; after reset the slot store is swept to zero, one
// entry a cycle; o_s_tready stays low during the sweep
// a stalled result holds in the result register while the input register
// still takes one more item; o_cfg_ready is always high
//
module dmx512_frame_transmitter #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: tdata = slot_index[8:0], slot_data[16:9], zero pad [23:17]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dmxtx_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                               i_s_tuser,   // operation
    // master side: tdata = line_level[0], sync_level[1], zero pad [7:2]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dmxtx_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmxtx_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dmxtx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dmxtx_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic                   r_in_valid;
    logic                   r_in_op;
    logic [SLOT_IDX_W-1:0]  r_in_idx;
    logic [SLOT_DATA_W-1:0] r_in_data;

    // result register
    logic r_out_valid;
    logic r_out_line;
    logic r_out_sync;

    logic                   w_busy;
    logic                   w_out_free;
    logic                   w_proc;
    logic                   w_accept;
    logic                   w_tick;
    logic                   w_we;
    logic [AW-1:0]          w_raddr;
    logic [SLOT_DATA_W-1:0] w_rd_byte;
    logic                   w_line;
    logic                   w_sync;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_period <= FRAME_PERIOD_RST;
            r_cfg.slot_count   <= SLOT_COUNT_RST;
            r_cfg.break_ticks  <= BREAK_TICKS_RST;
            r_cfg.mab_ticks    <= MAB_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_FRAME_PERIOD: r_cfg.frame_period <= i_cfg_data;
                REG_SLOT_COUNT:   r_cfg.slot_count   <= i_cfg_data[SLOT_COUNT_W-1:0];
                REG_BREAK_TICKS:  r_cfg.break_ticks  <= i_cfg_data[TICKS_W-1:0];
                REG_MAB_TICKS:    r_cfg.mab_ticks    <= i_cfg_data[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: the input register moves on whenever the result register
    // is empty or is being drained this cycle
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_s_tready = !w_busy && (!r_in_valid || w_proc);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_s_tuser;
            r_in_idx  <= i_s_tdata[SLOT_IDX_W-1:0];
            r_in_data <= i_s_tdata[SLOT_IDX_W +: SLOT_DATA_W];
        end
    end

    // writes past the store are dropped
    assign w_tick = w_proc && (r_in_op == OP_TICK);
    assign w_we   = w_proc && (r_in_op == OP_WRITE) &&
                    ({1'b0, r_in_idx} < (SLOT_IDX_W+1)'(MAX_SLOTS));

    dmxtx_store #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_in_idx[AW-1:0]),
        .i_wdata (r_in_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_byte),
        .o_busy  (w_busy)
    );

    dmxtx_seq #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (w_tick),
        .i_cfg     (r_cfg),
        .i_rd_byte (w_rd_byte),
        .o_raddr   (w_raddr),
        .o_line    (w_line),
        .o_sync    (w_sync)
    );

    // every item gives one result: the pin levels after it is handled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_line <= w_line;
            r_out_sync <= w_sync;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-2){1'b0}}, r_out_sync, r_out_line};

`ifndef SYNTHESIS
    a_no_item_during_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !r_in_valid)
        else $error("item held in the input register during the store sweep");

    a_item_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free) |=> r_out_valid)
        else $error("item in the input register produced no result");

    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> w_busy)
        else $error("store sweep did not start after reset");
`endif

endmodule

// File: bench/dmx512_frame_transmitter_tb.sv
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter_tb
// self-checking bench: ticks and slot writes stream in, line/sync levels are
// compared against a cycle-free model of the frame sequencer, across several
// register settings with random stalls on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dmx512_frame_transmitter_tb;
    import dmxtx_pkg::*;

    localparam int STORE_DEPTH = 512;
    localparam int PAD_W       = S_TDATA_W - SLOT_DATA_W - SLOT_IDX_W;

    typedef struct {
        logic                   op;
        logic [SLOT_IDX_W-1:0]  idx;
        logic [SLOT_DATA_W-1:0] data;
    } t_item;

    typedef struct {
        logic line;
        logic sync_lv;
    } t_levels;

    typedef enum logic [2:0] {
        LINE_IDLE, LINE_BREAK, LINE_MAB, LINE_SC_LOW, LINE_SC_HIGH, LINE_SLOTS
    } t_frame_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = OP_TICK;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = REG_FRAME_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dmx512_frame_transmitter #(
        .MAX_SLOTS (STORE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // slot_index, slot_data, zero pad
        .i_s_tuser   (i_s_tuser),   // operation
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // line_level, sync_level, zero pad
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // line model: registers, slot store and frame sequencer state
    // ------------------------------------------------------------------------
    logic [FRAME_PERIOD_W-1:0] tx_period;
    logic [SLOT_COUNT_W-1:0]   tx_slots;
    logic [TICKS_W-1:0]        tx_break;
    logic [TICKS_W-1:0]        tx_mab;

    logic [SLOT_DATA_W-1:0]    slot_store [STORE_DEPTH];
    logic [FRAME_PERIOD_W-1:0] elapsed;      // ticks since the last break start
    t_frame_step               fstep;
    logic [TICKS_W-1:0]        step_count;   // ticks spent in the timed phase
    logic [SLOT_COUNT_W-1:0]   slot_no;
    logic [BIT_POS_W-1:0]      bit_no;
    logic                      line_q;
    logic                      sync_q;

    // bookkeeping
    t_item   queued_items [$];
    t_levels expected_levels [$];
    t_item   bus_item;
    int      items_queued   = 0;
    int      items_accepted = 0;
    int      levels_checked = 0;
    int      errors         = 0;
    int      ticks_done     = 0;
    int      writes_done    = 0;
    int      frames_started = 0;
    int      slots_sent     = 0;
    int      settings_used  = 0;
    int      send_idle      = 0;
    int      hold_left      = 0;
    bit      long_hold_done = 1'b0;
    bit      gaps_on        = 1'b1;

    function automatic void clear_line_model();
        tx_period  = FRAME_PERIOD_RST;
        tx_slots   = SLOT_COUNT_RST;
        tx_break   = BREAK_TICKS_RST;
        tx_mab     = MAB_TICKS_RST;
        foreach (slot_store[k]) slot_store[k] = '0;
        elapsed    = '0;
        fstep      = LINE_IDLE;
        step_count = '0;
        slot_no    = '0;
        bit_no     = '0;
        line_q     = 1'b1;
        sync_q     = 1'b0;
    endfunction

    // slot count above the store depth is clipped to the store depth
    function automatic int unsigned active_slots();
        return (tx_slots > STORE_DEPTH) ? STORE_DEPTH : int'(tx_slots);
    endfunction

    // a zero length still lasts one tick
    function automatic bit phase_over(input int unsigned len);
        if ({24'd0, step_count} + 32'd1 >= len) begin
            step_count = '0;
            return 1'b1;
        end
        step_count++;
        return 1'b0;
    endfunction

    // apply one accepted item and return the levels the pins then show
    function automatic t_levels dmx_advance(input t_item it);
        t_levels lv;
        logic    lvl;
        logic    syn;
        if (it.op == OP_WRITE) begin
            // write leaves the pins as they are
            slot_store[it.idx] = it.data;
            writes_done++;
        end else begin
            lvl = 1'b1;
            syn = 1'b0;
            // period reached while idle, or overrun: break starts now
            if (fstep == LINE_IDLE && elapsed >= tx_period) begin
                fstep      = LINE_BREAK;
                step_count = '0;
                elapsed    = '0;
                frames_started++;
            end
            case (fstep)
                LINE_BREAK: begin
                    lvl = 1'b0;
                    if (phase_over(tx_break)) fstep = LINE_MAB;
                end
                LINE_MAB: begin
                    syn = 1'b1;
                    if (phase_over(tx_mab)) fstep = LINE_SC_LOW;
                end
                LINE_SC_LOW: begin
                    lvl = 1'b0;
                    syn = 1'b1;
                    if (phase_over(SC_LOW_TICKS)) fstep = LINE_SC_HIGH;
                end
                LINE_SC_HIGH: begin
                    if (phase_over(SC_HIGH_TICKS)) begin
                        slot_no = '0;
                        bit_no  = '0;
                        fstep   = (active_slots() == 0) ? LINE_IDLE : LINE_SLOTS;
                    end
                end
                LINE_SLOTS: begin
                    // start bit, data bits read live from the store, stop bits
                    if (bit_no == '0) begin
                        lvl = 1'b0;
                    end else if (bit_no <= LAST_DATA_POS) begin
                        lvl = (slot_no < STORE_DEPTH) ?
                              slot_store[slot_no[SLOT_IDX_W-1:0]][bit_no - 1'b1] : 1'b0;
                    end
                    if (bit_no >= LAST_BIT_POS) begin
                        bit_no  = '0;
                        slot_no = slot_no + 1'b1;
                        slots_sent++;
                        if (slot_no >= active_slots()) begin
                            slot_no = '0;
                            fstep   = LINE_IDLE;
                        end
                    end else begin
                        bit_no = bit_no + 1'b1;
                    end
                end
                default: begin
                    fstep = LINE_IDLE;
                end
            endcase
            if (elapsed != '1) elapsed = elapsed + 1'b1;
            line_q = lvl;
            sync_q = syn;
            ticks_done++;
        end
        lv.line    = line_q;
        lv.sync_lv = sync_q;
        return lv;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // input stream driver: walks the item queue, random gaps between transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // accepted item: predict its levels right away, in transfer order
            if (i_s_tvalid && o_s_tready) begin
                expected_levels.push_back(dmx_advance(bus_item));
                items_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    i_s_tvalid <= 1'b0;
                end else if (queued_items.size() > 0) begin
                    bus_item = queued_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= bus_item.op;
                    i_s_tdata  <= {{PAD_W{1'b0}}, bus_item.data, bus_item.idx};
                    send_idle = (gaps_on && $urandom_range(0, 99) < 35) ? gap_length() : 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side ready: random stalls, plus one long hold-off so the block
    // backs up and drops its input ready while items keep being offered
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!long_hold_done && levels_checked >= 600) begin
            long_hold_done = 1'b1;
            hold_left = 399;
            i_m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 30) begin
            hold_left = gap_length() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: every result transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_levels.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected, tdata %h", o_m_tdata));
            end else begin
                want = expected_levels.pop_front();
                if (o_m_tdata[0] !== want.line)
                    flag_mismatch($sformatf("result %0d line_level got %b want %b",
                                            levels_checked, o_m_tdata[0], want.line));
                if (o_m_tdata[1] !== want.sync_lv)
                    flag_mismatch($sformatf("result %0d sync_level got %b want %b",
                                            levels_checked, o_m_tdata[1], want.sync_lv));
            end
            levels_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    task automatic queue_item(input logic op, input int idx, input int data);
        t_item it;
        it.op   = op;
        it.idx  = idx[SLOT_IDX_W-1:0];
        it.data = data[SLOT_DATA_W-1:0];
        queued_items.push_back(it);
        items_queued++;
    endtask

    // mostly ticks; writes favor the first few slots so the data shows up
    task automatic queue_random(input int count, input int tick_pct);
        int idx;
        for (int n = 0; n < count; n++) begin
            idx = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7)
                                               : $urandom_range(0, STORE_DEPTH - 1);
            queue_item(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE,
                       idx, $urandom_range(0, 255));
        end
    endtask

    // all issued items transferred and all results back, then let the
    // pipeline settle
    task automatic wait_quiet();
        int guard;
        guard = 0;
        while (items_accepted != items_queued) @(posedge i_clk);
        while (expected_levels.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        while (expected_levels.size() != 0) begin
            void'(expected_levels.pop_front());
            flag_mismatch("expected result never arrived");
        end
        repeat (4) @(posedge i_clk);
    endtask

    // register writes, one transfer per register, back to back
    task automatic load_settings(input t_cfg c);
        logic [CFG_ADDR_W-1:0] regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{REG_FRAME_PERIOD, REG_SLOT_COUNT, REG_BREAK_TICKS, REG_MAB_TICKS};
        vals = '{c.frame_period, CFG_DATA_W'(c.slot_count),
                 CFG_DATA_W'(c.break_ticks), CFG_DATA_W'(c.mab_ticks)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (regs[k])
                REG_FRAME_PERIOD: tx_period = vals[k];
                REG_SLOT_COUNT:   tx_slots  = vals[k][SLOT_COUNT_W-1:0];
                REG_BREAK_TICKS:  tx_break  = vals[k][TICKS_W-1:0];
                REG_MAB_TICKS:    tx_mab    = vals[k][TICKS_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [TICKS_W-1:0] random_ticks(input int hi);
        return ($urandom_range(0, 99) < 85) ? TICKS_W'($urandom_range(0, hi))
                                            : TICKS_W'($urandom_range(0, 255));
    endfunction

    initial begin
        t_cfg cfg;
        int   r;

        clear_line_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short period, short frame; store extremes written before any tick
        load_settings('{frame_period: 16'd40, slot_count: 10'd2,
                        break_ticks: 8'd1, mab_ticks: 8'd1});
        queue_item(OP_WRITE, 0, 8'hFF);
        queue_item(OP_WRITE, STORE_DEPTH - 1, 8'h00);
        queue_item(OP_WRITE, STORE_DEPTH - 1, 8'hFF);
        queue_item(OP_WRITE, 1, 8'h00);
        queue_item(OP_WRITE, 0, 8'h5A);
        queue_item(OP_WRITE, 1, 8'hA5);
        for (int n = 0; n < 19; n++) queue_item(OP_TICK, 0, 0);
        queue_random(150, 85);
        wait_quiet();

        // period zero overruns every frame; zero break and mark last one tick
        gaps_on = 1'b0;
        load_settings('{frame_period: 16'd0, slot_count: 10'd1,
                        break_ticks: 8'd0, mab_ticks: 8'd0});
        queue_random(150, 80);
        wait_quiet();
        gaps_on = 1'b1;

        // upper extremes, slot count beyond the store
        load_settings('{frame_period: 16'hFFFF, slot_count: 10'h3FF,
                        break_ticks: 8'hFF, mab_ticks: 8'hFF});
        queue_random(300, 95);
        wait_quiet();

        // short break and mark ahead of a frame that uses every slot
        load_settings('{frame_period: 16'd300, slot_count: 10'd512,
                        break_ticks: 8'd3, mab_ticks: 8'd2});
        queue_random(200, 85);
        wait_quiet();

        // random settings, mostly short frames so many complete
        for (int p = 0; p < 6; p++) begin
            r = $urandom_range(0, 99);
            cfg.frame_period = (r < 12) ? 16'hFFFF :
                               (r < 25) ? 16'($urandom_range(0, 39)) :
                                          16'($urandom_range(40, 140));
            r = $urandom_range(0, 99);
            cfg.slot_count   = (r < 85) ? 10'($urandom_range(0, 6)) :
                               (r < 92) ? 10'd512 : 10'($urandom_range(7, 1023));
            cfg.break_ticks  = random_ticks(6);
            cfg.mab_ticks    = random_ticks(4);
            gaps_on = (p != 2);
            load_settings(cfg);
            queue_random(180, 80);
            wait_quiet();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d items (%0d ticks, %0d slot writes) over %0d register settings",
                 items_accepted, ticks_done, writes_done, settings_used);
        $display("%0d frames started, %0d data slots sent, %0d results checked",
                 frames_started, slots_sent, levels_checked);
        if (errors == 0) begin
            $display("dmx512_frame_transmitter_tb passed");
        end else begin
            $display("dmx512_frame_transmitter_tb failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial begin
        #10_000_000;
        $display("timeout after %0d of %0d items", items_accepted, items_queued);
        $display("dmx512_frame_transmitter_tb failed");
        $finish;
    end

endmodule
